### hw/rtl/rebe_pkg.sv
// ---------------------------------------------------------------------------
// Rotary encoder and button event package
// Shared event codes, register indexes, reset values and types for the
// rotary encoder and push button event core.
// ---------------------------------------------------------------------------
package rebe_pkg;

   // Event codes carried on the result channel.
   localparam logic [2:0] EV_RIGHT = 3'd0;
   localparam logic [2:0] EV_LEFT  = 3'd1;
   localparam logic [2:0] EV_DOWN  = 3'd2;
   localparam logic [2:0] EV_PRESS = 3'd3;
   localparam logic [2:0] EV_UP    = 3'd4;
   localparam logic [2:0] EV_LONG  = 3'd5;
   localparam logic [2:0] EV_HOLD  = 3'd6;

   // Register indexes (word address bits of the configuration port).
   localparam logic [1:0] REG_QUIET  = 2'd0;
   localparam logic [1:0] REG_SETTLE = 2'd1;
   localparam logic [1:0] REG_LONG   = 2'd2;
   localparam logic [1:0] REG_HOLD   = 2'd3;

   // Register reset values.
   localparam logic [7:0]  QUIET_RESET  = 8'd3;
   localparam logic [7:0]  SETTLE_RESET = 8'd5;
   localparam logic [15:0] LONG_RESET   = 16'd500;
   localparam logic [15:0] HOLD_RESET   = 16'd1000;

   // Encoder history patterns for one detent.
   localparam logic [3:0] HIST_RIGHT_A = 4'b1101;
   localparam logic [3:0] HIST_RIGHT_B = 4'b0010;
   localparam logic [3:0] HIST_LEFT_A  = 4'b1110;
   localparam logic [3:0] HIST_LEFT_B  = 4'b0001;

   // Milliseconds to seconds: x / 1000 == (x * RECIP) >> 38 for any 32-bit x.
   localparam logic [31:0] MS_TO_S_RECIP = 32'h10624DD3;
   localparam int unsigned MS_TO_S_SHIFT = 38;

   // Most events one input word can cause.
   localparam int unsigned NUM_SLOTS = 3;

   typedef struct packed {
      logic [7:0]  quiet_ms;
      logic [7:0]  settle_ms;
      logic [15:0] long_ms;
      logic [15:0] hold_ms;
   } cfg_type;

   typedef struct packed {
      logic        operation;
      logic        clk_level;
      logic        dt_level;
      logic        switch_level;
      logic [31:0] now_ms;
   } item_type;

   // One pending event; to_seconds marks a value still in milliseconds.
   typedef struct packed {
      logic [2:0]  code;
      logic [31:0] value;
      logic        to_seconds;
   } evt_type;

endpackage

### hw/rtl/rebe_decode.sv
// ---------------------------------------------------------------------------
// Encoder and button decode
// Holds the encoder and button state and turns one input word into an
// ordered list of up to three events combinationally.
// ---------------------------------------------------------------------------
module rebe_decode (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         accept,
   input  rebe_pkg::item_type                           item,
   input  rebe_pkg::cfg_type                            cfg,
   output rebe_pkg::evt_type [rebe_pkg::NUM_SLOTS-1:0]  events,
   output logic [1:0]                                   count
);
   import rebe_pkg::*;

   localparam int unsigned NUM_CAND = 6;

   // State registers and their next values.
   logic [3:0]  hist_ff, hist_in;
   logic [31:0] last_rot_ff, last_rot_in;
   logic [31:0] pos_ff, pos_in;
   logic        stable_ff, stable_in;
   logic        pending_ff, pending_in;
   logic [31:0] seen_ff, seen_in;
   logic        bdown_ff, bdown_in;
   logic        lr_ff, lr_in;
   logic [31:0] pst_ff, pst_in;
   logic [31:0] lht_ff, lht_in;
   logic [31:0] pcount_ff, pcount_in;

   // Intermediate state after the encoder and switch stages.
   logic        bdown_a, lr_a;
   logic [31:0] lht_a, lht_b;

   logic [15:0] lp, hr;
   logic [31:0] since_rot, since_edge, since_press, held_ms, since_hold;
   logic [3:0]  hist_shift;

   logic ev_right, ev_left, ev_down, ev_press, ev_up, ev_long, ev_hold;
   evt_type [NUM_CAND-1:0] cand;
   logic    [NUM_CAND-1:0] cand_v;
   logic [2:0] n_cnt;

   // A zero threshold behaves as one millisecond.
   assign lp = (cfg.long_ms == 16'd0) ? 16'd1 : cfg.long_ms;
   assign hr = (cfg.hold_ms == 16'd0) ? 16'd1 : cfg.hold_ms;

   assign since_rot   = item.now_ms - last_rot_ff;
   assign since_edge  = item.now_ms - seen_ff;
   assign since_press = item.now_ms - pst_ff;
   assign hist_shift  = {hist_ff[1:0], item.clk_level, item.dt_level};

   // Encoder history and switch debounce.
   always_comb begin
      hist_in     = hist_ff;
      last_rot_in = last_rot_ff;
      pos_in      = pos_ff;
      stable_in   = stable_ff;
      pending_in  = pending_ff;
      seen_in     = seen_ff;
      bdown_a     = bdown_ff;
      lr_a        = lr_ff;
      pst_in      = pst_ff;
      lht_a       = lht_ff;
      pcount_in   = pcount_ff;
      ev_right    = 1'b0;
      ev_left     = 1'b0;
      ev_down     = 1'b0;
      ev_press    = 1'b0;
      ev_up       = 1'b0;
      if (item.operation) begin
         // Clear keeps position and press count.
         hist_in     = 4'd0;
         last_rot_in = 32'd0;
         stable_in   = item.switch_level;
         pending_in  = 1'b0;
         seen_in     = 32'd0;
         bdown_a     = 1'b0;
         lr_a        = 1'b0;
         pst_in      = 32'd0;
         lht_a       = 32'd0;
      end else begin
         if (since_rot >= {24'd0, cfg.quiet_ms}) begin
            hist_in = hist_shift;
            if (hist_shift == HIST_RIGHT_A || hist_shift == HIST_RIGHT_B) begin
               last_rot_in = item.now_ms;
               pos_in      = pos_ff + 32'd1;
               ev_right    = 1'b1;
            end else if (hist_shift == HIST_LEFT_A || hist_shift == HIST_LEFT_B) begin
               last_rot_in = item.now_ms;
               pos_in      = pos_ff - 32'd1;
               ev_left     = 1'b1;
            end
         end
         if (item.switch_level != stable_ff) begin
            if (!pending_ff) begin
               pending_in = 1'b1;
               seen_in    = item.now_ms;
            end else if (since_edge >= {24'd0, cfg.settle_ms}) begin
               pending_in = 1'b0;
               stable_in  = item.switch_level;
               if (!item.switch_level) begin
                  bdown_a = 1'b1;
                  pst_in  = item.now_ms;
                  lr_a    = 1'b0;
                  lht_a   = item.now_ms;
                  ev_down = 1'b1;
               end else begin
                  if (bdown_ff && !lr_ff && since_press < {16'd0, lp}) begin
                     pcount_in = pcount_ff + 32'd1;
                     ev_press  = 1'b1;
                  end
                  bdown_a = 1'b0;
                  ev_up   = 1'b1;
               end
            end
         end else begin
            pending_in = 1'b0;
         end
      end
   end

   // Long press and hold repeat, on the state left by the switch stage.
   assign held_ms    = item.now_ms - pst_in;
   assign ev_long    = bdown_a && !lr_a && (held_ms >= {16'd0, lp});
   assign lht_b      = ev_long ? item.now_ms : lht_a;
   assign since_hold = item.now_ms - lht_b;
   assign ev_hold    = bdown_a && (lr_a || ev_long) && (since_hold >= {16'd0, hr});
   assign bdown_in   = bdown_a;
   assign lr_in      = lr_a || ev_long;
   assign lht_in     = ev_hold ? item.now_ms : lht_b;

   // Candidate events in delivery order.
   always_comb begin
      cand[0] = '{code: EV_RIGHT, value: pos_in,    to_seconds: 1'b0};
      cand[1] = '{code: EV_LEFT,  value: pos_in,    to_seconds: 1'b0};
      cand[2] = '{code: EV_DOWN,  value: 32'd0,     to_seconds: 1'b0};
      cand[3] = '{code: EV_PRESS, value: pcount_in, to_seconds: 1'b0};
      cand[4] = '{code: EV_UP,    value: 32'd0,     to_seconds: 1'b0};
      cand[5] = '{code: EV_LONG,  value: held_ms,   to_seconds: 1'b1};
      if (ev_hold) begin
         cand[5].code = EV_HOLD;
      end
      cand_v = {ev_long || ev_hold, ev_up, ev_press, ev_down, ev_left, ev_right};
   end

   // Pack the fired events into consecutive slots.
   always_comb begin
      n_cnt  = 3'd0;
      events = '0;
      for (int i = 0; i < NUM_CAND; i++) begin
         if (cand_v[i]) begin
            if (n_cnt < 3'(NUM_SLOTS)) begin
               events[n_cnt[1:0]] = cand[i];
            end
            n_cnt = n_cnt + 3'd1;
         end
      end
      count = n_cnt[1:0];
   end

   // Long and hold cannot both fire for one word, so they share a candidate.
   // State update on every accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff     <= 4'd0;
         last_rot_ff <= 32'd0;
         pos_ff      <= 32'd0;
         stable_ff   <= 1'b1;
         pending_ff  <= 1'b0;
         seen_ff     <= 32'd0;
         bdown_ff    <= 1'b0;
         lr_ff       <= 1'b0;
         pst_ff      <= 32'd0;
         lht_ff      <= 32'd0;
         pcount_ff   <= 32'd0;
      end else if (accept) begin
         hist_ff     <= hist_in;
         last_rot_ff <= last_rot_in;
         pos_ff      <= pos_in;
         stable_ff   <= stable_in;
         pending_ff  <= pending_in;
         seen_ff     <= seen_in;
         bdown_ff    <= bdown_in;
         lr_ff       <= lr_in;
         pst_ff      <= pst_in;
         lht_ff      <= lht_in;
         pcount_ff   <= pcount_in;
      end
   end

endmodule

### hw/rtl/rotary_encoder_button_events_core.sv
// ---------------------------------------------------------------------------
// Rotary encoder and button event core
// Decodes quadrature encoder samples and a debounced push button into
// rotation, press, release, long-press and hold events.
//
//   Channel  Direction  Carries
//   req_     in         one pin sample or clear command per word
//   rsp_     out        one event per word, tlast on the last of a word's events
//   csr_     in/out     APB-style register access, four registers of 8 or 16 bits
//
// A sample is decoded in the cycle it is accepted; its events (up to three) sit
// in a slot buffer and leave through the output register, one per cycle while
// rsp_tready is high. Long and hold values turn from milliseconds into seconds
// by one multiply. A new word is taken when the slot buffer is empty or its last
// event leaves in that cycle, so with rsp_tready high a word with at most one
// event sustains one word per clock; a word with more events holds the input
// until its last event leaves. Reset is synchronous. With rsp_tready low the
// output register holds its word and the input stalls while events are buffered.
// ---------------------------------------------------------------------------
module rotary_encoder_button_events_core (
   input  logic        clock,
   input  logic        reset,
   // Input words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // clk_level, dt_level, switch_level, now_ms[31:0], zero pad
   input  logic [0:0]  req_tuser,   // operation
   // Result words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // event_value
   output logic [2:0]  rsp_tuser,   // event_code
   output logic        rsp_tlast,   // last_of_run
   // Register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rebe_pkg::*;

   cfg_type  cfg_ff;
   item_type item;
   logic     accept;
   logic     csr_write;

   evt_type [NUM_SLOTS-1:0] dec_events;
   logic    [1:0]           dec_count;

   evt_type [NUM_SLOTS-1:0] slot_ff;
   logic    [1:0]           rem_ff, rem_in;
   logic                    out_load;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_code_ff;
   logic [31:0] rsp_value_ff;
   logic        rsp_last_ff;
   logic [63:0] product;
   logic [31:0] seconds;

   // Register port: always ready, word address in paddr[3:2].
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quiet_ms  <= QUIET_RESET;
         cfg_ff.settle_ms <= SETTLE_RESET;
         cfg_ff.long_ms   <= LONG_RESET;
         cfg_ff.hold_ms   <= HOLD_RESET;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_QUIET:  cfg_ff.quiet_ms  <= csr_pwdata[7:0];
            REG_SETTLE: cfg_ff.settle_ms <= csr_pwdata[7:0];
            REG_LONG:   cfg_ff.long_ms   <= csr_pwdata[15:0];
            REG_HOLD:   cfg_ff.hold_ms   <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_QUIET:  csr_prdata = {24'd0, cfg_ff.quiet_ms};
         REG_SETTLE: csr_prdata = {24'd0, cfg_ff.settle_ms};
         REG_LONG:   csr_prdata = {16'd0, cfg_ff.long_ms};
         REG_HOLD:   csr_prdata = {16'd0, cfg_ff.hold_ms};
         default:    csr_prdata = 32'd0;
      endcase
   end

   // Unpack the input word.
   assign item.operation    = req_tuser[0];
   assign item.clk_level    = req_tdata[0];
   assign item.dt_level     = req_tdata[1];
   assign item.switch_level = req_tdata[2];
   assign item.now_ms       = req_tdata[34:3];

   // Take a word when the slot buffer is empty or its last event leaves now.
   assign out_load   = (rem_ff != 2'd0) && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (rem_ff == 2'd0) || ((rem_ff == 2'd1) && out_load);
   assign accept     = req_tvalid && req_tready;

   rebe_decode u_decode (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (item),
      .cfg    (cfg_ff),
      .events (dec_events),
      .count  (dec_count)
   );

   // Slot buffer: loaded with a word's events, shifted down as each leaves.
   always_comb begin
      if (accept) begin
         rem_in = dec_count;
      end else if (out_load) begin
         rem_in = rem_ff - 2'd1;
      end else begin
         rem_in = rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 2'd0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff <= dec_events;
      end else if (out_load) begin
         for (int i = 0; i < NUM_SLOTS - 1; i++) begin
            slot_ff[i] <= slot_ff[i+1];
         end
      end
   end

   // Milliseconds to whole seconds by reciprocal multiply.
   assign product = {32'd0, slot_ff[0].value} * {32'd0, MS_TO_S_RECIP};
   assign seconds = 32'(product[63:MS_TO_S_SHIFT]);

   // Output register.
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_code_ff  <= slot_ff[0].code;
         rsp_value_ff <= slot_ff[0].to_seconds ? seconds : slot_ff[0].value;
         rsp_last_ff  <= (rem_ff == 2'd1);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_code_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### sim/rotary_encoder_button_events_core_test.sv
// ----------------------------------------------------------------------------
// Rotary encoder and button event core testbench
// Streams pin samples and clear commands into the core and checks every event
// word against an in-bench prediction of the decoder and debounce logic. The
// run steps through several register settings, with random idling on both
// streams in most settings and one long receiver stall per selected setting.
// ----------------------------------------------------------------------------
module rotary_encoder_button_events_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rebe_pkg::*;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;
   localparam logic [31:0] MS_PER_SECOND = 32'd1000;
   localparam int unsigned STALL_CYCLES = 100;

   typedef struct {
      logic [2:0]  code;
      logic [31:0] value;
      logic        last;
   } dial_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // clk_level, dt_level, switch_level, now_ms[31:0], zero pad
   logic [0:0]  req_tuser = '0;   // operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // event_value
   logic [2:0]  rsp_tuser;        // event_code
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   rotary_encoder_button_events_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // Register copies used by the event prediction.
   logic [7:0]  quiet_cfg  = QUIET_RESET;
   logic [7:0]  settle_cfg = SETTLE_RESET;
   logic [15:0] long_cfg   = LONG_RESET;
   logic [15:0] hold_cfg   = HOLD_RESET;

   // Predicted decoder and button state.
   logic [3:0]  line_hist = '0;
   logic [31:0] last_turn_ms = '0;
   logic [31:0] dial_pos = '0;
   logic        sw_stable = 1'b1;
   logic        sw_edge_waiting = 1'b0;
   logic [31:0] sw_edge_ms = '0;
   logic        btn_down = 1'b0;
   logic        long_done = 1'b0;
   logic [31:0] press_ms = '0;
   logic [31:0] hold_ms_last = '0;
   logic [31:0] press_total = '0;

   item_type       sample_queue[$];
   item_type       word_on_bus;
   dial_event_type awaited_events[$];
   dial_event_type item_events[$];

   int unsigned words_queued = 0;
   int unsigned words_taken = 0;
   int unsigned error_count = 0;
   int unsigned squeeze_req = 0;
   int unsigned squeeze_done = 0;
   int unsigned stall_left = 0;
   logic        steady = 1'b0;

   // Stimulus generator state.
   logic [31:0] t_now = '0;
   int unsigned enc_idx = 0;
   logic        sw_now = 1'b1;
   logic [1:0]  gray_seq [4] = '{2'b11, 2'b01, 2'b00, 2'b10};

   function automatic void note_event(input logic [2:0] code, input logic [31:0] value);
      item_events.push_back('{code, value, 1'b0});
   endfunction

   // Works out the events that one accepted word causes and queues them.
   task automatic predict_events(input item_type w);
      logic [31:0] lp_ms;
      logic [31:0] hr_ms;
      logic [31:0] held;
      lp_ms = (long_cfg == '0) ? 32'd1 : {16'd0, long_cfg};
      hr_ms = (hold_cfg == '0) ? 32'd1 : {16'd0, hold_cfg};
      item_events.delete();
      if (w.operation == OP_CLEAR) begin
         line_hist = '0;
         last_turn_ms = '0;
         sw_stable = w.switch_level;
         sw_edge_waiting = 1'b0;
         sw_edge_ms = '0;
         btn_down = 1'b0;
         long_done = 1'b0;
         press_ms = '0;
         hold_ms_last = '0;
         return;
      end
      // Encoder history, ignored inside the quiet window after a step.
      if (w.now_ms - last_turn_ms >= {24'd0, quiet_cfg}) begin
         line_hist = {line_hist[1:0], w.clk_level, w.dt_level};
         if (line_hist == HIST_RIGHT_A || line_hist == HIST_RIGHT_B) begin
            last_turn_ms = w.now_ms;
            dial_pos = dial_pos + 32'd1;
            note_event(EV_RIGHT, dial_pos);
         end else if (line_hist == HIST_LEFT_A || line_hist == HIST_LEFT_B) begin
            last_turn_ms = w.now_ms;
            dial_pos = dial_pos - 32'd1;
            note_event(EV_LEFT, dial_pos);
         end
      end
      // A changed switch level must persist for the settle time.
      if (w.switch_level != sw_stable) begin
         if (!sw_edge_waiting) begin
            sw_edge_waiting = 1'b1;
            sw_edge_ms = w.now_ms;
         end else if (w.now_ms - sw_edge_ms >= {24'd0, settle_cfg}) begin
            sw_edge_waiting = 1'b0;
            sw_stable = w.switch_level;
            if (!w.switch_level) begin
               btn_down = 1'b1;
               press_ms = w.now_ms;
               long_done = 1'b0;
               hold_ms_last = w.now_ms;
               note_event(EV_DOWN, '0);
            end else begin
               if (btn_down && !long_done && (w.now_ms - press_ms) < lp_ms) begin
                  press_total = press_total + 32'd1;
                  note_event(EV_PRESS, press_total);
               end
               btn_down = 1'b0;
               note_event(EV_UP, '0);
            end
         end
      end else begin
         sw_edge_waiting = 1'b0;
      end
      // Long press fires once, then hold repeats.
      held = w.now_ms - press_ms;
      if (btn_down && !long_done && held >= lp_ms) begin
         long_done = 1'b1;
         hold_ms_last = w.now_ms;
         note_event(EV_LONG, held / MS_PER_SECOND);
      end
      if (btn_down && long_done && (w.now_ms - hold_ms_last) >= hr_ms) begin
         hold_ms_last = w.now_ms;
         note_event(EV_HOLD, held / MS_PER_SECOND);
      end
      if (item_events.size() > 0) begin
         item_events[item_events.size() - 1].last = 1'b1;
      end
      foreach (item_events[k]) begin
         awaited_events.push_back(item_events[k]);
      end
   endtask

   // Input stream driver.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_events(word_on_bus);
            words_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (sample_queue.size() > 0 && (steady || $urandom_range(0, 99) >= 22)) begin
               word_on_bus = sample_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {5'd0, word_on_bus.now_ms, word_on_bus.switch_level,
                             word_on_bus.dt_level, word_on_bus.clk_level};
               req_tuser <= word_on_bus.operation;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result stream monitor and checker.
   always @(posedge clock) begin
      dial_event_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_events.size() == 0) begin
               $display("%0t ns: unexpected event, expected none, got code %0d value %0d last %0b",
                        $time, rsp_tuser, $signed(rsp_tdata), rsp_tlast);
               error_count++;
            end else begin
               want = awaited_events.pop_front();
               if (rsp_tuser !== want.code || rsp_tdata !== want.value ||
                   rsp_tlast !== want.last) begin
                  $display("%0t ns: expected code %0d value %0d last %0b, got code %0d value %0d last %0b",
                           $time, want.code, $signed(want.value), want.last,
                           rsp_tuser, $signed(rsp_tdata), rsp_tlast);
                  error_count++;
               end
            end
         end
         // A requested squeeze holds the receiver off so the core backs up.
         if (squeeze_done != squeeze_req) begin
            squeeze_done = squeeze_req;
            stall_left = STALL_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(0, 99) >= 22);
         end
      end
   end

   task automatic queue_word(input logic op, input logic clk_lvl, input logic dt_lvl,
                             input logic sw, input logic [31:0] now);
      item_type w;
      w.operation = op;
      w.clk_level = clk_lvl;
      w.dt_level = dt_lvl;
      w.switch_level = sw;
      w.now_ms = now;
      sample_queue.push_back(w);
      words_queued++;
   endtask

   task automatic queue_sample(input logic sw, input int unsigned gap);
      t_now = t_now + gap;
      queue_word(OP_SAMPLE, gray_seq[enc_idx][1], gray_seq[enc_idx][0], sw, t_now);
   endtask

   task automatic turn_knob(input bit cw);
      enc_idx = cw ? (enc_idx + 1) % 4 : (enc_idx + 3) % 4;
   endtask

   // One stretch of random stimulus: a knob turn, a press, noise or a clear.
   task automatic add_segment();
      int unsigned pick;
      int unsigned lp_eff;
      int unsigned hr_eff;
      int unsigned span;
      int unsigned step;
      int unsigned parts;
      bit cw;
      pick = $urandom_range(0, 9);
      lp_eff = (long_cfg == '0) ? 1 : long_cfg;
      hr_eff = (hold_cfg == '0) ? 1 : hold_cfg;
      if (pick <= 2) begin
         cw = $urandom_range(0, 1);
         repeat ($urandom_range(2, 8)) begin
            turn_knob(cw);
            if ($urandom_range(0, 4) == 0) begin
               queue_sample(sw_now, $urandom_range(0, quiet_cfg));
            end else begin
               queue_sample(sw_now, quiet_cfg + $urandom_range(0, 5));
            end
         end
      end else if (pick <= 6) begin
         queue_sample(1'b0, $urandom_range(1, 20));
         if ($urandom_range(0, 4) == 0) begin
            // Contact bounce drops the pending edge.
            queue_sample(1'b1, $urandom_range(0, settle_cfg));
            queue_sample(1'b0, 1);
         end
         queue_sample(1'b0, settle_cfg + $urandom_range(0, 3));
         case ($urandom_range(0, 2))
            0: span = $urandom_range(0, lp_eff / 2);
            1: span = (lp_eff > 15) ? lp_eff - $urandom_range(0, 15) : 0;
            default: span = lp_eff + $urandom_range(0, 3 * hr_eff);
         endcase
         parts = $urandom_range(1, 4);
         repeat (parts) begin
            step = (parts == 1) ? span : $urandom_range(0, span);
            span -= step;
            parts--;
            if ($urandom_range(0, 3) == 0) begin
               turn_knob($urandom_range(0, 1));
            end
            queue_sample(1'b0, step);
         end
         queue_sample(1'b1, $urandom_range(1, 10));
         if ($urandom_range(0, 2) == 0) begin
            turn_knob($urandom_range(0, 1));
         end
         queue_sample(1'b1, settle_cfg + $urandom_range(0, 2));
         sw_now = 1'b1;
      end else if (pick <= 8) begin
         repeat ($urandom_range(3, 6)) begin
            enc_idx = $urandom_range(0, 3);
            sw_now = $urandom_range(0, 1);
            if ($urandom_range(0, 3) == 0) begin
               queue_sample(sw_now, $urandom);
            end else begin
               queue_sample(sw_now, $urandom_range(0, 2 * settle_cfg + 2));
            end
         end
      end else begin
         sw_now = $urandom_range(0, 1);
         queue_word(OP_CLEAR, $urandom_range(0, 1), $urandom_range(0, 1), sw_now, $urandom);
      end
   endtask

   // Waits until every word has been taken and every event has arrived.
   task automatic wait_idle();
      while (words_taken != words_queued || awaited_events.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
   endtask

   // Register write followed by a read back of the same register.
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
      logic [31:0] stored;
      case (idx)
         REG_QUIET: begin
            quiet_cfg = data[7:0];
            stored = {24'd0, data[7:0]};
         end
         REG_SETTLE: begin
            settle_cfg = data[7:0];
            stored = {24'd0, data[7:0]};
         end
         REG_LONG: begin
            long_cfg = data[15:0];
            stored = {16'd0, data[15:0]};
         end
         default: begin
            hold_cfg = data[15:0];
            stored = {16'd0, data[15:0]};
         end
      endcase
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== stored) begin
         $display("%0t ns: register %0d read back expected %0h, got %0h",
                  $time, idx, stored, csr_prdata);
         error_count++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Upper bits beyond each register's width carry noise.
   task automatic set_config(input logic [7:0] q, input logic [7:0] s,
                             input logic [15:0] l, input logic [15:0] h);
      write_reg(REG_QUIET, ($urandom << 8) | q);
      write_reg(REG_SETTLE, ($urandom << 8) | s);
      write_reg(REG_LONG, ($urandom << 16) | l);
      write_reg(REG_HOLD, ($urandom << 16) | h);
   endtask

   task automatic run_phase(input int unsigned count);
      int unsigned base;
      base = words_queued;
      while (words_queued - base < count) begin
         add_segment();
      end
      wait_idle();
   endtask

   // Main sequence: directed words on reset settings, then random phases.
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Start-up quiet window, right and left detents, a quiet-window skip.
      queue_word(OP_SAMPLE, 1'b1, 1'b1, 1'b1, 32'd0);
      queue_word(OP_SAMPLE, 1'b1, 1'b1, 1'b1, 32'd10);
      queue_word(OP_SAMPLE, 1'b0, 1'b1, 1'b1, 32'd20);
      queue_word(OP_SAMPLE, 1'b0, 1'b0, 1'b1, 32'd21);
      queue_word(OP_SAMPLE, 1'b0, 1'b0, 1'b1, 32'd30);
      queue_word(OP_SAMPLE, 1'b1, 1'b0, 1'b1, 32'd40);
      queue_word(OP_SAMPLE, 1'b1, 1'b1, 1'b1, 32'd50);
      queue_word(OP_SAMPLE, 1'b1, 1'b0, 1'b1, 32'd60);
      queue_word(OP_SAMPLE, 1'b0, 1'b0, 1'b1, 32'd70);
      queue_word(OP_SAMPLE, 1'b0, 1'b1, 1'b1, 32'd80);
      // Short press, then a long press with one hold event.
      queue_word(OP_SAMPLE, 1'b0, 1'b1, 1'b0, 32'd100);
      queue_word(OP_SAMPLE, 1'b0, 1'b1, 1'b0, 32'd105);
      queue_word(OP_SAMPLE, 1'b0, 1'b1, 1'b1, 32'd200);
      queue_word(OP_SAMPLE, 1'b0, 1'b1, 1'b1, 32'd205);
      queue_word(OP_SAMPLE, 1'b0, 1'b1, 1'b0, 32'd300);
      queue_word(OP_SAMPLE, 1'b0, 1'b1, 1'b0, 32'd305);
      queue_word(OP_SAMPLE, 1'b0, 1'b1, 1'b0, 32'd805);
      queue_word(OP_SAMPLE, 1'b0, 1'b1, 1'b0, 32'd1805);
      // Clear while held, then a press across the timestamp wrap whose
      // release lands together with a detent.
      queue_word(OP_CLEAR, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
      queue_word(OP_SAMPLE, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFF0);
      queue_word(OP_SAMPLE, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFF8);
      queue_word(OP_SAMPLE, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFC);
      queue_word(OP_SAMPLE, 1'b0, 1'b1, 1'b1, 32'h0000_0010);
      queue_word(OP_SAMPLE, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF);
      queue_word(OP_SAMPLE, 1'b0, 1'b0, 1'b0, 32'd0);
      wait_idle();

      // Smallest and largest settings, then long and hold values of zero.
      set_config(8'd0, 8'd0, 16'd1, 16'd1);
      run_phase(45);
      set_config(8'd255, 8'd255, 16'd65535, 16'd65535);
      squeeze_req++;
      run_phase(45);
      set_config($urandom_range(0, 255), $urandom_range(0, 255), 16'd0, 16'd0);
      run_phase(45);
      // Typical settings with both streams running flat out.
      steady <= 1'b1;
      set_config($urandom_range(1, 10), $urandom_range(1, 20),
                 $urandom_range(50, 2000), $urandom_range(50, 2000));
      squeeze_req++;
      run_phase(45);
      steady <= 1'b0;
      set_config($urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 65535), $urandom_range(0, 65535));
      run_phase(45);

      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog for a stuck handshake.
   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

### files.f
hw/rtl/rebe_pkg.sv
hw/rtl/rebe_decode.sv
hw/rtl/rotary_encoder_button_events_core.sv
sim/rotary_encoder_button_events_core_test.sv
